// ===== rtl/esd_pkg.sv =====
package esd_pkg;

  // Sizing of the dispatcher
  localparam int NUM_EVENTS      = 4;
  localparam int MAX_SUBSCRIBERS = 8;
  localparam int AGENT_ID_BITS   = 8;
  localparam int MAX_RESULTS     = 32;

  // Field widths on the channels
  localparam int ACTION_W = 2;
  localparam int EVENT_W  = 2;
  localparam int AGENT_W  = 8;
  localparam int KIND_W   = 2;

  // Derived internal widths
  localparam int EV_W    = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
  localparam int SUB_W   = (MAX_SUBSCRIBERS > 1) ? $clog2(MAX_SUBSCRIBERS) : 1;
  localparam int CNT_W   = $clog2(MAX_SUBSCRIBERS + 1);
  localparam int RES_W   = $clog2(MAX_RESULTS + 1);
  localparam int SUM_W   = ((RES_W > CNT_W) ? RES_W : CNT_W) + 1;
  localparam int DEPTH   = NUM_EVENTS * MAX_SUBSCRIBERS;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SUBSCRIBE = 2'd0,
    ACT_PUBLISH   = 2'd1,
    ACT_RUN       = 2'd2,
    ACT_NONE      = 2'd3
  } action_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_SUB_ACK  = 2'd0,
    KIND_PUB_ACK  = 2'd1,
    KIND_DISPATCH = 2'd2,
    KIND_EMPTY    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FETCH,
    S_DISP,
    S_DONE
  } state_t;

endpackage

// ===== rtl/esd_req_if.sv =====
interface esd_req_if;
  import esd_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [EVENT_W-1:0]  event_num;
  logic [AGENT_W-1:0]  agent_num;

  modport source(output valid, output action, output event_num, output agent_num,
                 input ready);
  modport sink(input valid, input action, input event_num, input agent_num,
               output ready);
endinterface

// ===== rtl/esd_rsp_if.sv =====
interface esd_rsp_if;
  import esd_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  result_kind;
  logic               accepted;
  logic [EVENT_W-1:0] target_event;
  logic [AGENT_W-1:0] target_agent;
  logic               last_of_run;

  modport source(output valid, output result_kind, output accepted, output target_event,
                 output target_agent, output last_of_run, input ready);
  modport sink(input valid, input result_kind, input accepted, input target_event,
               input target_agent, input last_of_run, output ready);
endinterface

// ===== rtl/event_subscribe_dispatcher_core.sv =====
// Publish-subscribe dispatcher. A subscribe request appends an agent to an
// event's list (refused when the list is full) and a publish request marks the
// event pending; each returns one acknowledgement. A run request walks the
// events in ascending order and for each pending one emits its subscribers in
// subscription order, each fetched in a state of its own through the single
// port of the subscriber table before its dispatch state; it stops at the first
// pending event that overruns the result budget, and a run with nothing to send
// gives one empty result. The block takes one request at a time and is not
// ready until the last result of the current request has been handed to the
// output register. No clearing pass runs after reset: counts and pending flags
// clear at once.
module event_subscribe_dispatcher_core (
  input  logic      clk,
  input  logic      rst,
  esd_req_if.sink   req,
  esd_rsp_if.source rsp
);
  import esd_pkg::*;

  state_t state, state_next;

  // Latched request
  action_t                  req_action;
  logic [EVENT_W-1:0]       req_event;
  logic [AGENT_ID_BITS-1:0] req_agent;
  logic                     ev_ok;

  // Table state
  logic [CNT_W-1:0]      sub_count      [NUM_EVENTS];
  logic [CNT_W-1:0]      sub_count_next [NUM_EVENTS];
  logic [NUM_EVENTS-1:0] pending, pending_next;
  logic [AGENT_ID_BITS-1:0] table_mem [DEPTH];
  logic [AGENT_ID_BITS-1:0] rd_data;

  // Sequencer registers
  logic [EV_W-1:0]  ev_idx, ev_idx_next;
  logic [SUB_W-1:0] sub_idx, sub_idx_next;
  logic [RES_W-1:0] n_res, n_res_next;
  logic                     held_valid, held_valid_next;
  logic [AGENT_ID_BITS-1:0] held_agent, held_agent_next;
  logic [EVENT_W-1:0]       held_event, held_event_next;

  // Output register
  logic               out_valid, out_valid_next;
  kind_t              out_kind, out_kind_next;
  logic               out_acc, out_acc_next;
  logic [EVENT_W-1:0] out_event, out_event_next;
  logic [AGENT_W-1:0] out_agent, out_agent_next;
  logic               out_last, out_last_next;

  logic             slot_free;
  logic             mem_we, mem_re;
  logic [SUB_W-1:0] sub_sel;
  logic [ADDR_W-1:0] mem_addr;
  logic [CNT_W-1:0] cnt_cur;
  logic             last_ev;
  logic             no_fit;

  assign req.ready = (state == S_IDLE);
  assign slot_free = !out_valid || rsp.ready;
  assign cnt_cur   = sub_count[ev_idx];
  assign last_ev   = (ev_idx == EV_W'(NUM_EVENTS - 1));
  assign no_fit    = (SUM_W'(n_res) + SUM_W'(cnt_cur)) > SUM_W'(MAX_RESULTS);

  // One table port: write slot on subscribe, scan slot otherwise
  assign sub_sel  = (state == S_EXEC) ? SUB_W'(cnt_cur) : sub_idx;
  assign mem_addr = ADDR_W'(ev_idx) * ADDR_W'(MAX_SUBSCRIBERS) + ADDR_W'(sub_sel);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_addr] <= req_agent;
    end
    if (mem_re) begin
      rd_data <= table_mem[mem_addr];
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_action <= action_t'(req.action);
      req_event  <= req.event_num;
      req_agent  <= AGENT_ID_BITS'(req.agent_num);
      ev_ok      <= 32'(req.event_num) < NUM_EVENTS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pending    <= '0;
      out_valid  <= 1'b0;
      held_valid <= 1'b0;
      ev_idx     <= '0;
      n_res      <= '0;
      for (int i = 0; i < NUM_EVENTS; i++) begin
        sub_count[i] <= '0;
      end
    end else begin
      state      <= state_next;
      pending    <= pending_next;
      out_valid  <= out_valid_next;
      held_valid <= held_valid_next;
      ev_idx     <= ev_idx_next;
      n_res      <= n_res_next;
      for (int i = 0; i < NUM_EVENTS; i++) begin
        sub_count[i] <= sub_count_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    sub_idx    <= sub_idx_next;
    held_agent <= held_agent_next;
    held_event <= held_event_next;
    out_kind   <= out_kind_next;
    out_acc    <= out_acc_next;
    out_event  <= out_event_next;
    out_agent  <= out_agent_next;
    out_last   <= out_last_next;
  end

  // Sequencer
  always_comb begin
    state_next      = state;
    pending_next    = pending;
    sub_count_next  = sub_count;
    ev_idx_next     = ev_idx;
    sub_idx_next    = sub_idx;
    n_res_next      = n_res;
    held_valid_next = held_valid;
    held_agent_next = held_agent;
    held_event_next = held_event;
    out_valid_next  = out_valid && !rsp.ready;
    out_kind_next   = out_kind;
    out_acc_next    = out_acc;
    out_event_next  = out_event;
    out_agent_next  = out_agent;
    out_last_next   = out_last;
    mem_we          = 1'b0;
    mem_re          = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          ev_idx_next = EV_W'(req.event_num);
          state_next  = S_EXEC;
        end
      end

      S_EXEC: begin
        unique case (req_action)
          ACT_SUBSCRIBE: begin
            if (slot_free) begin
              out_valid_next = 1'b1;
              out_kind_next  = KIND_SUB_ACK;
              out_acc_next   = ev_ok && (cnt_cur < CNT_W'(MAX_SUBSCRIBERS));
              out_event_next = req_event;
              out_agent_next = AGENT_W'(req_agent);
              out_last_next  = 1'b1;
              // Append the agent when the list has room
              if (ev_ok && (cnt_cur < CNT_W'(MAX_SUBSCRIBERS))) begin
                mem_we                 = 1'b1;
                sub_count_next[ev_idx] = cnt_cur + CNT_W'(1);
              end
              state_next = S_IDLE;
            end
          end
          ACT_PUBLISH: begin
            if (slot_free) begin
              out_valid_next = 1'b1;
              out_kind_next  = KIND_PUB_ACK;
              out_acc_next   = 1'b0;
              out_event_next = req_event;
              out_agent_next = '0;
              out_last_next  = 1'b1;
              if (ev_ok) begin
                pending_next[ev_idx] = 1'b1;
              end
              state_next = S_IDLE;
            end
          end
          ACT_RUN: begin
            ev_idx_next     = '0;
            n_res_next      = '0;
            held_valid_next = 1'b0;
            state_next      = S_SCAN;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end

      // Look at one event per cycle
      S_SCAN: begin
        if (pending[ev_idx] && no_fit) begin
          state_next = S_DONE;
        end else if (pending[ev_idx] && (cnt_cur != '0)) begin
          pending_next[ev_idx] = 1'b0;
          sub_idx_next         = '0;
          state_next           = S_FETCH;
        end else begin
          pending_next[ev_idx] = 1'b0;
          if (last_ev) begin
            state_next = S_DONE;
          end else begin
            ev_idx_next = ev_idx + EV_W'(1);
          end
        end
      end

      S_FETCH: begin
        mem_re     = 1'b1;
        state_next = S_DISP;
      end

      // Push the previous dispatch out, hold the new one
      S_DISP: begin
        if (!held_valid || slot_free) begin
          if (held_valid) begin
            out_valid_next = 1'b1;
            out_kind_next  = KIND_DISPATCH;
            out_acc_next   = 1'b0;
            out_event_next = held_event;
            out_agent_next = AGENT_W'(held_agent);
            out_last_next  = 1'b0;
          end
          held_valid_next = 1'b1;
          held_agent_next = rd_data;
          held_event_next = EVENT_W'(ev_idx);
          n_res_next      = n_res + RES_W'(1);
          if ((CNT_W'(sub_idx) + CNT_W'(1)) == cnt_cur) begin
            if (last_ev) begin
              state_next = S_DONE;
            end else begin
              ev_idx_next = ev_idx + EV_W'(1);
              state_next  = S_SCAN;
            end
          end else begin
            sub_idx_next = sub_idx + SUB_W'(1);
            state_next   = S_FETCH;
          end
        end
      end

      // Close the run: final dispatch or the empty marker
      S_DONE: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_acc_next   = 1'b0;
          out_last_next  = 1'b1;
          if (held_valid) begin
            out_kind_next  = KIND_DISPATCH;
            out_event_next = held_event;
            out_agent_next = AGENT_W'(held_agent);
          end else begin
            out_kind_next  = KIND_EMPTY;
            out_event_next = '0;
            out_agent_next = '0;
          end
          held_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign rsp.valid        = out_valid;
  assign rsp.result_kind  = out_kind;
  assign rsp.accepted     = out_acc;
  assign rsp.target_event = out_event;
  assign rsp.target_agent = out_agent;
  assign rsp.last_of_run  = out_last;

  // A held dispatch exists only while a run is in progress
  a_held_in_run: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> (state == S_SCAN || state == S_FETCH || state == S_DISP ||
                    state == S_DONE))
    else $error("held dispatch outside a run");

  // A run never exceeds its result budget
  a_result_budget: assert property (@(posedge clk) disable iff (rst)
    32'(n_res) <= MAX_RESULTS)
    else $error("run result count over budget");

  // Dispatches name only real events
  a_dispatch_event: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.result_kind == KIND_DISPATCH) |-> 32'(rsp.target_event) < NUM_EVENTS)
    else $error("dispatch for an event that does not exist");

  // Subscriber counts stay within the list size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(cnt_cur) <= MAX_SUBSCRIBERS)
    else $error("subscriber count over list size");

endmodule

// ===== tb/sv/tb_event_subscribe_dispatcher_core.sv =====
`timescale 1ns / 1ps

module tb_event_subscribe_dispatcher_core;
  import esd_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 24;
  localparam int ITEMS_PER_PHASE = 62;
  localparam int LONG_HOLD       = 300;
  localparam logic [AGENT_W-1:0] AGENT_KEEP = AGENT_W'((1 << AGENT_ID_BITS) - 1);

  typedef struct {
    kind_t              kind;
    logic               accepted;
    logic [EVENT_W-1:0] event_id;
    logic [AGENT_W-1:0] agent;
    logic               last;
  } outcome_t;

  // Track subscriber lists and pending flags, and queue the results they imply
  class dispatch_scoreboard;
    logic [AGENT_W-1:0] sub_table [NUM_EVENTS][MAX_SUBSCRIBERS];
    int unsigned        sub_count [NUM_EVENTS];
    bit                 pending [NUM_EVENTS];
    outcome_t           expected_q[$];
    int                 errors;
    int                 checked;
    int                 requests;
    int                 runs;
    int                 dispatches;
    int                 refusals;

    function new();
      for (int e = 0; e < NUM_EVENTS; e++) begin
        sub_count[e] = 0;
        pending[e]   = 1'b0;
      end
      errors     = 0;
      checked    = 0;
      requests   = 0;
      runs       = 0;
      dispatches = 0;
      refusals   = 0;
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 60) $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    function void note_request(action_t act, logic [EVENT_W-1:0] ev,
                               logic [AGENT_W-1:0] agent);
      outcome_t    o;
      int          n;
      int unsigned cnt;
      logic [AGENT_W-1:0] kept;
      kept = agent & AGENT_KEEP;
      requests++;
      case (act)
        ACT_SUBSCRIBE: begin
          o = '{kind: KIND_SUB_ACK, accepted: 1'b0, event_id: ev, agent: kept, last: 1'b1};
          // append unless the list is full
          if (int'(ev) < NUM_EVENTS && sub_count[ev] < MAX_SUBSCRIBERS) begin
            sub_table[ev][sub_count[ev]] = kept;
            sub_count[ev]++;
            o.accepted = 1'b1;
          end else begin
            refusals++;
          end
          expected_q.push_back(o);
        end
        ACT_PUBLISH: begin
          if (int'(ev) < NUM_EVENTS) pending[ev] = 1'b1;
          o = '{kind: KIND_PUB_ACK, accepted: 1'b0, event_id: ev, agent: '0, last: 1'b1};
          expected_q.push_back(o);
        end
        ACT_RUN: begin
          runs++;
          n = 0;
          // scan events in ascending order; stop at the first one that does not fit
          for (int e = 0; e < NUM_EVENTS; e++) begin
            if (!pending[e]) continue;
            cnt = sub_count[e];
            if (n + int'(cnt) > MAX_RESULTS) break;
            pending[e] = 1'b0;
            for (int i = 0; i < int'(cnt); i++) begin
              o = '{kind: KIND_DISPATCH, accepted: 1'b0, event_id: EVENT_W'(e),
                    agent: sub_table[e][i], last: 1'b0};
              expected_q.push_back(o);
              n++;
            end
          end
          if (n == 0) begin
            o = '{kind: KIND_EMPTY, accepted: 1'b0, event_id: '0, agent: '0, last: 1'b1};
            expected_q.push_back(o);
          end else begin
            expected_q[expected_q.size() - 1].last = 1'b1;
            dispatches += n;
          end
        end
        default: ;  // unused code: nothing happens
      endcase
    endfunction

    task check_result(outcome_t got);
      outcome_t want;
      checked++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0d agent=%0d",
                                  got.kind, got.agent));
      end else begin
        want = expected_q.pop_front();
        if (got.kind !== want.kind)
          report_mismatch($sformatf("result_kind %0d, want %0d", got.kind, want.kind));
        if (got.accepted !== want.accepted)
          report_mismatch($sformatf("accepted %0b, want %0b", got.accepted, want.accepted));
        if (got.event_id !== want.event_id)
          report_mismatch($sformatf("target_event %0d, want %0d",
                                    got.event_id, want.event_id));
        if (got.agent !== want.agent)
          report_mismatch($sformatf("target_agent %0d, want %0d", got.agent, want.agent));
        if (got.last !== want.last)
          report_mismatch($sformatf("last_of_run %0b, want %0b", got.last, want.last));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   hold_cycles;
  int   cycle_count;

  esd_req_if req();
  esd_rsp_if rsp();

  dispatch_scoreboard sb = new();

  event_subscribe_dispatcher_core DUT (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stall the result side at random, or for a long stretch on request
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        rsp.ready <= 1'b0;
        hold_cycles--;
      end else begin
        rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Check every accepted result
  always @(posedge clk) begin : result_monitor
    outcome_t got;
    if (!rst && rsp.valid && rsp.ready) begin
      got.kind     = kind_t'(rsp.result_kind);
      got.accepted = rsp.accepted;
      got.event_id = rsp.target_event;
      got.agent    = rsp.target_agent;
      got.last     = rsp.last_of_run;
      sb.check_result(got);
    end
  end

  // Bound the run
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still awaited",
               cycle_count, sb.expected_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one request, entered and left at a falling edge
  task send_request(action_t act, logic [EVENT_W-1:0] ev, logic [AGENT_W-1:0] agent);
    if ($urandom_range(99) < tx_idle_pct) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req.valid     <= 1'b1;
    req.action    <= act;
    req.event_num <= ev;
    req.agent_num <= agent;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sb.note_request(act, ev, agent);
    @(negedge clk);
  endtask

  // Hold the request side until every expected result has arrived
  task wait_drained();
    req.valid <= 1'b0;
    do @(negedge clk); while (sb.expected_q.size() != 0);
  endtask

  task directed_requests();
    static logic [AGENT_W-1:0] fill [MAX_SUBSCRIBERS] = '{8'h00, 8'hFF, 8'h55, 8'hAA,
                                                          8'h01, 8'h02, 8'h03, 8'h80};
    // run on an empty table, then the unused code
    send_request(ACT_RUN, 2'd0, 8'h00);
    send_request(ACT_NONE, 2'd3, 8'hFF);
    // pending event without subscribers
    send_request(ACT_PUBLISH, 2'd3, 8'h00);
    send_request(ACT_RUN, 2'd0, 8'h00);
    // fill event 0 and overflow it once
    for (int i = 0; i < MAX_SUBSCRIBERS; i++) send_request(ACT_SUBSCRIBE, 2'd0, fill[i]);
    send_request(ACT_SUBSCRIBE, 2'd0, 8'h7F);
    // duplicates and the other events
    send_request(ACT_SUBSCRIBE, 2'd1, 8'hFF);
    send_request(ACT_SUBSCRIBE, 2'd1, 8'hFF);
    send_request(ACT_SUBSCRIBE, 2'd3, 8'h0F);
    send_request(ACT_SUBSCRIBE, 2'd2, 8'hF0);
    // publish everything, one twice, and dispatch
    for (int e = 0; e < NUM_EVENTS; e++) send_request(ACT_PUBLISH, EVENT_W'(e), 8'hC3);
    send_request(ACT_PUBLISH, 2'd0, 8'h00);
    send_request(ACT_RUN, 2'd3, 8'hFF);
    send_request(ACT_RUN, 2'd1, 8'h00);
    send_request(ACT_NONE, 2'd0, 8'h00);
  endtask

  task random_requests(int count);
    int      sent;
    int      pick;
    action_t act;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 40)      act = ACT_SUBSCRIBE;
      else if (pick < 70) act = ACT_PUBLISH;
      else if (pick < 95) act = ACT_RUN;
      else                act = ACT_NONE;
      send_request(act, EVENT_W'($urandom_range(NUM_EVENTS - 1)),
                   AGENT_W'($urandom_range(255)));
      if (act != ACT_NONE) sent++;
    end
  endtask

  // Stall the receiver for a long stretch while requests keep coming
  task pressure_burst();
    hold_cycles = LONG_HOLD;
    for (int e = 0; e < NUM_EVENTS; e++) send_request(ACT_PUBLISH, EVENT_W'(e), 8'h00);
    send_request(ACT_RUN, 2'd0, 8'h00);
    send_request(ACT_SUBSCRIBE, 2'd2, 8'h3C);
    send_request(ACT_PUBLISH, 2'd1, 8'h00);
    send_request(ACT_RUN, 2'd0, 8'h00);
    send_request(ACT_RUN, 2'd0, 8'h00);
  endtask

  initial begin
    rst           = 1'b1;
    req.valid     = 1'b0;
    req.action    = ACT_NONE;
    req.event_num = '0;
    req.agent_num = '0;
    tx_idle_pct   = 23;
    rx_idle_pct   = 63;
    hold_cycles   = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_requests();
    random_requests(ITEMS_PER_PHASE);
    wait_drained();

    tx_idle_pct = 63;
    rx_idle_pct = 23;
    random_requests(ITEMS_PER_PHASE);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    pressure_burst();
    wait_drained();
    random_requests(ITEMS_PER_PHASE);

    // drain and watch for stray results
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_q.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_q.size()));

    $display("Covered %0d requests including %0d runs and %0d refused subscribes",
             sb.requests, sb.runs, sb.refusals);
    $display("Checked %0d results, %0d of them dispatches, %0d mismatches",
             sb.checked, sb.dispatches, sb.errors);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/esd_pkg.sv
rtl/esd_req_if.sv
rtl/esd_rsp_if.sv
rtl/event_subscribe_dispatcher_core.sv
tb/sv/tb_event_subscribe_dispatcher_core.sv
